// ===== rtl/core/idw3_pkg.sv =====
`default_nettype none
package idw3_pkg;

  localparam int MAX_REFS = 64;
  localparam int REF_AW   = $clog2(MAX_REFS);
  localparam int CNT_W    = $clog2(MAX_REFS + 1);
  localparam int DIST_W   = 33;
  localparam int SUM_W    = 38;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_REF   = 1'b1;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  localparam logic MODE_VALUE  = 1'b0;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_REFS  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 4'd1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [31:0] ref_value;
    logic        last_ref;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  ref_index;
    logic [31:0] weight;
    logic [31:0] interp_value;
    logic [1:0]  status;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wr_data;
  } cfg_item_t;

  typedef struct packed {
    logic [3:0] power;
    logic       mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } query_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] v;
  } ref_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             ovf;
  } run_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/idw3_if.sv =====
`default_nettype none
interface idw3_in_if;
  logic               valid;
  logic               ready;
  idw3_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface idw3_out_if;
  logic                valid;
  logic                ready;
  idw3_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface idw3_cfg_if;
  logic                valid;
  logic                ready;
  idw3_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/idw3_ram.sv =====
`default_nettype none
module idw3_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/idw3_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit a cycle; quotient must fit 32 bits.
module idw3_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [63:0]                 num,
  input  wire logic [idw3_pkg::SUM_W-1:0]  den,
  output logic                             done,
  output logic [31:0]                      quo
);
  logic [idw3_pkg::SUM_W:0]   rem_r, rem_nxt;
  logic [idw3_pkg::SUM_W-1:0] den_r;
  logic [31:0]                low_r, quo_r;
  logic [4:0]                 cnt_r;
  logic                       run_r, done_r;
  logic [idw3_pkg::SUM_W:0]   trial;
  logic                       qbit;

  always_comb begin
    trial   = {rem_r[idw3_pkg::SUM_W-1:0], low_r[31]};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? (trial - {1'b0, den_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {{(idw3_pkg::SUM_W - 31){1'b0}}, num[63:32]};
      low_r <= num[31:0];
      den_r <= den;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== rtl/core/idw3_front.sv =====
`default_nettype none
// Accept items, fill the reference store, hand closed sets to the back end.
module idw3_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  idw3_in_if.sink                                in_ch,
  output logic                                   ref_we,
  output logic [idw3_pkg::REF_AW-1:0]            ref_waddr,
  output idw3_pkg::ref_entry_t                   ref_wdata,
  output idw3_pkg::query_t                       query,
  output idw3_pkg::run_cmd_t                     cmd,
  output logic                                   cmd_valid,
  input  wire logic                              cmd_pop,
  input  wire logic                              run_done
);
  idw3_pkg::query_t             query_r;
  logic [idw3_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         busy_r;
  logic                         qv_r;
  idw3_pkg::run_cmd_t           cmd_r;
  logic                         take, is_ref, room;

  assign in_ch.ready = !busy_r;
  assign take   = in_ch.valid && !busy_r;
  assign is_ref = (in_ch.data.req_type == idw3_pkg::REQ_REF);
  assign room   = (cnt_r < idw3_pkg::CNT_W'(idw3_pkg::MAX_REFS));

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (take && is_ref) begin
      if (room) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign ref_we    = take && is_ref && room;
  assign ref_waddr = cnt_r[idw3_pkg::REF_AW-1:0];
  assign ref_wdata = '{x: in_ch.data.coord_x, y: in_ch.data.coord_y,
                       z: in_ch.data.coord_z, v: in_ch.data.ref_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
      qv_r    <= 1'b0;
      cmd_r   <= '0;
    end else begin
      if (take && !is_ref) begin
        query_r <= '{x: in_ch.data.coord_x, y: in_ch.data.coord_y,
                     z: in_ch.data.coord_z};
      end
      if (cmd_pop) begin
        qv_r <= 1'b0;
      end
      if (run_done) begin
        busy_r <= 1'b0;
      end
      if (take && in_ch.data.last_ref) begin
        // close the set: queue it and hold off input until the run ends
        cmd_r  <= '{n: cnt_nxt, ovf: ovf_nxt};
        qv_r   <= 1'b1;
        busy_r <= 1'b1;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  assign query     = query_r;
  assign cmd       = cmd_r;
  assign cmd_valid = qv_r;
endmodule
`default_nettype wire

// ===== rtl/core/idw3_back.sv =====
`default_nettype none
// Sequencer over a closed set: distances, raw weights, normalisation, results.
module idw3_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire idw3_pkg::cfg_t          cfg,
  input  wire idw3_pkg::query_t        query,
  input  wire idw3_pkg::run_cmd_t      cmd,
  input  wire logic                    cmd_valid,
  output logic                         cmd_pop,
  output logic                         run_done,
  output logic [idw3_pkg::REF_AW-1:0]  ref_raddr,
  input  wire idw3_pkg::ref_entry_t    ref_rdata,
  idw3_out_if.source                   out_ch
);
  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001, S_D_RD  = 19'h00002, S_D_SQ0 = 19'h00004,
    S_D_SQ  = 19'h00008, S_D_RT  = 19'h00010, S_D_WR  = 19'h00020,
    S_W_RD  = 19'h00040, S_W_CHK = 19'h00080, S_W_DIV = 19'h00100,
    S_W_POW = 19'h00200, S_W_WR  = 19'h00400, S_N_RD  = 19'h00800,
    S_N_DV0 = 19'h01000, S_N_DIV = 19'h02000, S_N_MUL = 19'h04000,
    S_N_ACC = 19'h08000, S_FIN   = 19'h10000, S_EMIT  = 19'h20000,
    S_DONE  = 19'h40000
  } state_t;

  localparam int ACC_W = 71;

  state_t                          st_r;
  logic [idw3_pkg::CNT_W-1:0]      n_r, i_r;
  logic [31:0]                     mx_r, my_r, mz_r;
  logic [1:0]                      sq_cnt_r;
  logic [63:0]                     prod_r;
  logic [65:0]                     ssum_r;
  logic [37:0]                     rem_r;
  logic [idw3_pkg::DIST_W-1:0]     root_r, dmin_r;
  logic [5:0]                      rt_cnt_r;
  logic                            any_zero_r;
  logic [31:0]                     w_r, q_r, nw_r;
  logic [3:0]                      p_cnt_r;
  logic [idw3_pkg::SUM_W-1:0]      sum_r;
  logic signed [31:0]              v_r;
  logic signed [64:0]              sprod_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic                            emit_last_r;
  idw3_pkg::out_item_t             pend_r;
  idw3_pkg::out_item_t             out_r;
  logic                            ov_r;

  logic                            wk_we;
  logic [idw3_pkg::REF_AW-1:0]     wk_addr;
  logic [idw3_pkg::DIST_W-1:0]     wk_wdata, wk_rdata;
  logic                            div_start, div_done;
  logic [63:0]                     div_num;
  logic [idw3_pkg::SUM_W-1:0]      div_den;
  logic [31:0]                     div_quo;

  logic [32:0]                     dxs, dys, dzs;
  logic [31:0]                     sq_op;
  logic [37:0]                     rt_shift, rt_trial;
  logic [63:0]                     pow_prod;
  logic signed [ACC_W-1:0]         rnd;
  logic signed [ACC_W-32:0]        qv;
  logic [31:0]                     qsat;
  logic                            out_free;
  logic                            ov_load;

  assign wk_addr = i_r[idw3_pkg::REF_AW-1:0];
  assign ref_raddr = i_r[idw3_pkg::REF_AW-1:0];

  idw3_ram #(.W(idw3_pkg::DIST_W), .D(idw3_pkg::MAX_REFS)) u_work (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_addr),
    .wdata (wk_wdata),
    .raddr (wk_addr),
    .rdata (wk_rdata)
  );

  idw3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    dxs = {query.x[31], query.x} - {ref_rdata.x[31], ref_rdata.x};
    dys = {query.y[31], query.y} - {ref_rdata.y[31], ref_rdata.y};
    dzs = {query.z[31], query.z} - {ref_rdata.z[31], ref_rdata.z};
    unique case (sq_cnt_r)
      2'd0:    sq_op = mx_r;
      2'd1:    sq_op = my_r;
      default: sq_op = mz_r;
    endcase
    rt_shift = {rem_r[35:0], ssum_r[65:64]};
    rt_trial = {3'b000, root_r, 2'b01};
    pow_prod = w_r * q_r;
    rnd  = acc_r + (ACC_W'(1) <<< 30);
    qv   = rnd[ACC_W-1:31];
    if (qv > (ACC_W-31)'(32'sh7FFF_FFFF)) begin
      qsat = 32'h7FFF_FFFF;
    end else if (qv < -(ACC_W-31)'(33'sh0_8000_0000)) begin
      qsat = 32'h8000_0000;
    end else begin
      qsat = qv[31:0];
    end
    wk_we    = (st_r == S_D_WR) || (st_r == S_W_WR);
    wk_wdata = (st_r == S_D_WR) ? root_r : {1'b0, w_r};
    div_start = ((st_r == S_W_CHK) && !any_zero_r) || (st_r == S_N_DV0);
    if (st_r == S_W_CHK) begin
      div_num = {dmin_r[32:0], 31'b0};
      div_den = {5'b0, wk_rdata};
    end else begin
      div_num = {1'b0, wk_rdata[31:0], 31'b0} + {27'b0, sum_r[37:1]};
      div_den = sum_r;
    end
    out_free = !ov_r || out_ch.ready;
    ov_load  = (st_r == S_EMIT) && out_free;
  end

  assign cmd_pop  = (st_r == S_IDLE) && cmd_valid;
  assign run_done = (st_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (ov_load) begin
        ov_r <= 1'b1;
      end else if (ov_r && out_ch.ready) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            n_r        <= cmd.n;
            i_r        <= '0;
            dmin_r     <= '1;
            any_zero_r <= 1'b0;
            sum_r      <= '0;
            acc_r      <= '0;
            if (cmd.ovf) begin
              pend_r      <= '{result_kind: idw3_pkg::KIND_VALUE, ref_index: '0,
                               weight: '0, interp_value: '0,
                               status: idw3_pkg::ST_OVERFLOW, last_result: 1'b1};
              emit_last_r <= 1'b1;
              st_r        <= S_EMIT;
            end else if (cmd.n == '0) begin
              pend_r      <= '{result_kind: idw3_pkg::KIND_VALUE, ref_index: '0,
                               weight: '0, interp_value: '0,
                               status: idw3_pkg::ST_NO_REFS, last_result: 1'b1};
              emit_last_r <= 1'b1;
              st_r        <= S_EMIT;
            end else begin
              st_r <= S_D_RD;
            end
          end
        end
        S_D_RD: st_r <= S_D_SQ0;
        S_D_SQ0: begin
          mx_r     <= dxs[32] ? 32'(-dxs) : dxs[31:0];
          my_r     <= dys[32] ? 32'(-dys) : dys[31:0];
          mz_r     <= dzs[32] ? 32'(-dzs) : dzs[31:0];
          sq_cnt_r <= '0;
          ssum_r   <= '0;
          st_r     <= S_D_SQ;
        end
        S_D_SQ: begin
          prod_r   <= sq_op * sq_op;
          sq_cnt_r <= sq_cnt_r + 2'd1;
          if (sq_cnt_r != 2'd0) begin
            ssum_r <= ssum_r + {2'b00, prod_r};
          end
          if (sq_cnt_r == 2'd3) begin
            rem_r    <= '0;
            root_r   <= '0;
            rt_cnt_r <= '0;
            st_r     <= S_D_RT;
          end
        end
        S_D_RT: begin
          // two radicand bits per step, one root bit out
          ssum_r   <= {ssum_r[63:0], 2'b00};
          rt_cnt_r <= rt_cnt_r + 6'd1;
          if (rt_shift >= rt_trial) begin
            rem_r  <= rt_shift - rt_trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= rt_shift;
            root_r <= {root_r[31:0], 1'b0};
          end
          if (rt_cnt_r == 6'd32) begin
            st_r <= S_D_WR;
          end
        end
        S_D_WR: begin
          if (root_r == '0) begin
            any_zero_r <= 1'b1;
          end
          if (root_r < dmin_r) begin
            dmin_r <= root_r;
          end
          if (i_r + 1'b1 == n_r) begin
            i_r  <= '0;
            st_r <= S_W_RD;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_D_RD;
          end
        end
        S_W_RD: st_r <= S_W_CHK;
        S_W_CHK: begin
          if (any_zero_r) begin
            w_r  <= (wk_rdata == '0) ? idw3_pkg::ONE_Q31 : '0;
            st_r <= S_W_WR;
          end else begin
            st_r <= S_W_DIV;
          end
        end
        S_W_DIV: begin
          if (div_done) begin
            q_r     <= div_quo;
            w_r     <= idw3_pkg::ONE_Q31;
            p_cnt_r <= '0;
            st_r    <= S_W_POW;
          end
        end
        S_W_POW: begin
          if (p_cnt_r == cfg.power) begin
            st_r <= S_W_WR;
          end else begin
            w_r     <= pow_prod[62:31];
            p_cnt_r <= p_cnt_r + 4'd1;
          end
        end
        S_W_WR: begin
          sum_r <= sum_r + {6'b0, w_r};
          if (i_r + 1'b1 == n_r) begin
            i_r  <= '0;
            st_r <= S_N_RD;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_W_RD;
          end
        end
        S_N_RD: st_r <= S_N_DV0;
        S_N_DV0: begin
          v_r  <= ref_rdata.v;
          st_r <= S_N_DIV;
        end
        S_N_DIV: begin
          if (div_done) begin
            nw_r <= div_quo;
            if (cfg.mode == idw3_pkg::MODE_VALUE) begin
              st_r <= S_N_MUL;
            end else begin
              pend_r      <= '{result_kind: idw3_pkg::KIND_WEIGHT, ref_index: i_r[5:0],
                               weight: div_quo, interp_value: '0,
                               status: idw3_pkg::ST_OK,
                               last_result: (i_r + 1'b1 == n_r)};
              emit_last_r <= (i_r + 1'b1 == n_r);
              st_r        <= S_EMIT;
            end
          end
        end
        S_N_MUL: begin
          sprod_r <= $signed({1'b0, nw_r}) * v_r;
          st_r    <= S_N_ACC;
        end
        S_N_ACC: begin
          acc_r <= acc_r + ACC_W'(sprod_r);
          if (i_r + 1'b1 == n_r) begin
            st_r <= S_FIN;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_N_RD;
          end
        end
        S_FIN: begin
          pend_r      <= '{result_kind: idw3_pkg::KIND_VALUE, ref_index: '0,
                           weight: '0, interp_value: qsat,
                           status: idw3_pkg::ST_OK, last_result: 1'b1};
          emit_last_r <= 1'b1;
          st_r        <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_r <= pend_r;
            if (emit_last_r) begin
              st_r <= S_DONE;
            end else begin
              i_r  <= i_r + 1'b1;
              st_r <= S_N_RD;
            end
          end
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = out_r;
endmodule
`default_nettype wire

// ===== rtl/core/inverse_distance_weighting_3d_top.sv =====
`default_nettype none
// Channel  Direction  Payload                                    Transfer when
// in_ch    sink       req_type, coord_x/y/z, ref_value, last_ref valid && ready
// out_ch   source     result_kind, ref_index, weight, interp,... valid && ready
// cfg_ch   sink       reg_index, wr_data                         valid && ready
//
// A query or reference is accepted whenever input is not held off. A closing
// item starts a run over its set, in value mode or for weights, paced by the
// shared 32-step divider and the 33-step square root; a reference on the query
// point makes every weight step skip the divider and the power loop. Input is
// held off until the run has handed its last result to the output register.
// rst_n is synchronous, active low; the reference store needs no clearing.
module inverse_distance_weighting_3d_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  idw3_in_if.sink    in_ch,
  idw3_out_if.source out_ch,
  idw3_cfg_if.sink   cfg_ch
);
  idw3_pkg::cfg_t                  cfg_r;
  idw3_pkg::query_t                query;
  idw3_pkg::run_cmd_t              cmd;
  idw3_pkg::ref_entry_t            ref_wdata, ref_rdata;
  logic                            ref_we, cmd_valid, cmd_pop, run_done;
  logic [idw3_pkg::REF_AW-1:0]     ref_waddr, ref_raddr;

  // configuration is always taken; an unknown index is dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power <= 4'd3;
      cfg_r.mode  <= idw3_pkg::MODE_VALUE;
    end else if (cfg_ch.valid) begin
      priority if (cfg_ch.data.reg_index == idw3_pkg::CFG_POWER) begin
        cfg_r.power <= cfg_ch.data.wr_data[3:0];
      end else if (cfg_ch.data.reg_index == idw3_pkg::CFG_MODE) begin
        cfg_r.mode <= cfg_ch.data.wr_data[0];
      end else begin
        cfg_r <= cfg_r;
      end
    end
  end

  // front end: classify items, fill the store, queue closed sets
  idw3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ref_we    (ref_we),
    .ref_waddr (ref_waddr),
    .ref_wdata (ref_wdata),
    .query     (query),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .run_done  (run_done)
  );

  // reference store: written by the front end, read by the back end
  idw3_ram #(.W($bits(idw3_pkg::ref_entry_t)), .D(idw3_pkg::MAX_REFS)) u_refs (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  // back end: distances, weights, normalisation and result transfers
  idw3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .query     (query),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .run_done  (run_done),
    .ref_raddr (ref_raddr),
    .ref_rdata (ref_rdata),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire
